// File: hw/rtl/pknn_pkg.sv
// ----------------------------------------------------------------------------
// pknn_pkg
// Shared widths, defaults and register indexes for the preceding-points k-NN
// ----------------------------------------------------------------------------
package pknn_pkg;

    localparam int DEF_MAX_POINTS    = 1024;
    localparam int DEF_MAX_NEIGHBORS = 32;

    localparam int COORD_W = 24;
    localparam int SQ_W    = 52;
    localparam int DIST_W  = 25;
    localparam int PIDX_W  = 10;
    localparam int RANK_W  = 5;
    localparam int CFG_W   = 6;

    localparam logic CFG_NEIGHBOR_COUNT = 1'b0;
    localparam logic CFG_DIMENSIONS     = 1'b1;

    localparam logic [5:0] RST_NEIGHBOR_COUNT = 6'd15;
    localparam logic [1:0] RST_DIMENSIONS     = 2'd2;

    localparam logic [SQ_W-1:0] SQ_INF = {SQ_W{1'b1}};

endpackage

// File: hw/rtl/pknn_ram.sv
// ----------------------------------------------------------------------------
// pknn_ram
// Generic single-port RAM with registered read
// ----------------------------------------------------------------------------
module pknn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/pknn_isqrt.sv
// ----------------------------------------------------------------------------
// pknn_isqrt
// Bit-pair iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module pknn_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [pknn_pkg::SQ_W-1:0]     value,
    output logic                          done,
    output logic [pknn_pkg::DIST_W:0]     root
);

    import pknn_pkg::*;

    localparam int STEPS = SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [SQ_W-1:0]  rem_reg, rem_next;
    logic [SQ_W-1:0]  val_reg, val_next;
    logic [DIST_W:0]  root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SQ_W+1:0]  trial;
    logic [SQ_W+1:0]  cand;

    always_comb
    begin
        rem_next  = rem_reg;
        val_next  = val_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, val_reg[SQ_W-1 -: 2]};
        cand      = {{(SQ_W-DIST_W-1){1'b0}}, root_reg, 2'b01};
        if (go)
        begin
            rem_next  = '0;
            val_next  = value;
            root_next = '0;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[SQ_W-3:0], 2'b00};
            if (trial >= cand)
            begin
                rem_next  = SQ_W'(trial - cand);
                root_next = {root_reg[DIST_W-1:0], 1'b1};
            end
            else
            begin
                rem_next  = SQ_W'(trial);
                root_next = {root_reg[DIST_W-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hw/rtl/pknn_dist.sv
// ----------------------------------------------------------------------------
// pknn_dist
// Shared squared-difference unit: one axis per cycle while add is high, accumulates the sum
// ----------------------------------------------------------------------------
module pknn_dist (
    input  logic                                clk,
    input  logic                                clear,
    input  logic                                add,
    input  logic signed [pknn_pkg::COORD_W-1:0] a,
    input  logic signed [pknn_pkg::COORD_W-1:0] b,
    output logic [pknn_pkg::SQ_W-1:0]           sum
);

    import pknn_pkg::*;

    logic signed [COORD_W:0] diff;
    logic [COORD_W-1:0]      mag;
    logic [2*COORD_W-1:0]    prod;
    logic [SQ_W-1:0]         sum_reg;

    assign diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    assign mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
    assign prod = mag * mag;

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            sum_reg <= '0;
        end
        else if (add)
        begin
            sum_reg <= sum_reg + SQ_W'(prod);
        end
    end

    assign sum = sum_reg;

endmodule

// File: hw/rtl/preceding_points_knn.sv
// ----------------------------------------------------------------------------
// preceding_points_knn
// Brute-force k nearest preceding points, one shared distance unit
// ----------------------------------------------------------------------------
//  channel   ports                                        timing
//  config    cfg_we, cfg_index, cfg_data                  edge with cfg_we high
//  request   start, busy, restart, x/y/z_coord            start && !busy
//  result    result_valid, point_index .. last            one-cycle strobe
//
//  A point with index i scans each earlier point in turn: memory read, wait,
//  axis passes (z too in 3-D), compare. An inserted candidate moves entries
//  down one at a time to its slot. Each reported neighbor goes through the
//  bit-serial square root. Index 0 reports one result with neighbor_valid
//  low. Reset clears the control state only. Results cannot be stalled.
// ----------------------------------------------------------------------------
module preceding_points_knn #(
    parameter int MAX_POINTS    = pknn_pkg::DEF_MAX_POINTS,
    parameter int MAX_NEIGHBORS = pknn_pkg::DEF_MAX_NEIGHBORS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [pknn_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic                             restart,
    input  logic signed [pknn_pkg::COORD_W-1:0] x_coord,
    input  logic signed [pknn_pkg::COORD_W-1:0] y_coord,
    input  logic signed [pknn_pkg::COORD_W-1:0] z_coord,
    output logic                             result_valid,
    output logic [pknn_pkg::PIDX_W-1:0]      point_index,
    output logic [pknn_pkg::RANK_W-1:0]      neighbor_rank,
    output logic [pknn_pkg::PIDX_W-1:0]      neighbor_index,
    output logic [pknn_pkg::DIST_W-1:0]      distance,
    output logic                             neighbor_valid,
    output logic                             last
);

    import pknn_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int NW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int BW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_X     = 4'd4;
    localparam logic [3:0] S_Y     = 4'd5;
    localparam logic [3:0] S_Z     = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_INS   = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_SQW   = 4'd10;

    logic [5:0] ncount_reg;
    logic [1:0] dims_reg;

    logic [3:0]  state_reg, state_next;
    logic [AW:0] seen_reg, seen_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] j_reg, j_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic          three_reg, three_next;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;

    logic [SQ_W-1:0] best_sq_reg  [MAX_NEIGHBORS];
    logic [AW-1:0]   best_idx_reg [MAX_NEIGHBORS];
    logic [SQ_W-1:0] cand_reg;

    logic          accept;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic signed [COORD_W-1:0] rx, ry, rz;

    logic          dclear, dadd;
    logic signed [COORD_W-1:0] da, db;
    logic [SQ_W-1:0] dsum;

    logic          sq_go, sq_done;
    logic [DIST_W:0] sq_root;

    logic [5:0]    cnt_raw;
    logic [NW-1:0] cnt_sat;
    logic [NW-1:0] k_calc;
    logic [BW-1:0] pos_b, posm1_b, km1_b;
    logic          shift_en, place_en, init_best;

    logic           rv_reg;
    logic [RANK_W-1:0] rank_reg;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= RST_NEIGHBOR_COUNT;
            dims_reg   <= RST_DIMENSIONS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEIGHBOR_COUNT: ncount_reg <= cfg_data;
                CFG_DIMENSIONS:     dims_reg   <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    // clamp count to 1..MAX_NEIGHBORS
    assign cnt_raw = (ncount_reg == 6'd0) ? 6'd1 : ncount_reg;
    assign cnt_sat = (32'(cnt_raw) > MAX_NEIGHBORS) ? NW'(MAX_NEIGHBORS) : NW'(cnt_raw);

    assign ram_we   = accept;
    assign ram_addr = accept ? ((restart || seen_reg >= (AW+1)'(MAX_POINTS)) ? '0
                                : seen_reg[AW-1:0]) : j_reg;

    pknn_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_x (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(x_coord), .rdata(rx));
    pknn_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_y (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(y_coord), .rdata(ry));
    pknn_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_ram_z (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(z_coord), .rdata(rz));

    always_comb
    begin
        case (state_reg)
            S_Y:     begin da = py_reg; db = ry; end
            S_Z:     begin da = pz_reg; db = rz; end
            default: begin da = px_reg; db = rx; end
        endcase
    end

    assign dclear = (state_reg == S_WAIT);
    assign dadd   = (state_reg == S_X) || (state_reg == S_Y) || (state_reg == S_Z);

    pknn_dist u_dist (
        .clk(clk), .clear(dclear), .add(dadd), .a(da), .b(db), .sum(dsum));

    assign k_calc = (AW+1 > NW) ? ((ram_addr < AW'(cnt_sat)) ? NW'(ram_addr) : cnt_sat)
                                : ((NW'(ram_addr) < cnt_sat) ? NW'(ram_addr) : cnt_sat);

    assign pos_b   = BW'(pos_reg);
    assign posm1_b = BW'(pos_reg - 1'b1);
    assign km1_b   = BW'(k_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        cur_next   = cur_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        three_next = three_reg;
        shift_en   = 1'b0;
        place_en   = 1'b0;
        init_best  = 1'b0;
        sq_go      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next   = ram_addr;
                    seen_next  = {1'b0, ram_addr} + 1'b1;
                    three_next = (dims_reg == 2'd3);
                    k_next     = k_calc;
                    j_next     = '0;
                    init_best  = 1'b1;
                    state_next = (ram_addr == '0) ? S_FIRST : S_RD;
                end
            end
            S_FIRST: state_next = S_IDLE;
            S_RD:    state_next = S_WAIT;
            S_WAIT:  state_next = S_X;
            S_X:     state_next = S_Y;
            S_Y:     state_next = three_reg ? S_Z : S_CMP;
            S_Z:     state_next = S_CMP;
            S_CMP:
            begin
                if (dsum < best_sq_reg[km1_b])
                begin
                    pos_next   = k_reg - 1'b1;
                    state_next = S_INS;
                end
                else if (j_reg == cur_reg - 1'b1)
                begin
                    pos_next   = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_INS:
            begin
                // move one entry down per cycle until the slot is found
                if (pos_reg != '0 && best_sq_reg[posm1_b] > cand_reg)
                begin
                    shift_en = 1'b1;
                    pos_next = pos_reg - 1'b1;
                end
                else
                begin
                    place_en = 1'b1;
                    if (j_reg == cur_reg - 1'b1)
                    begin
                        pos_next   = '0;
                        state_next = S_SQ;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_SQ:
            begin
                sq_go      = 1'b1;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (sq_done)
                begin
                    if (pos_reg == k_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_SQ;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            rv_reg    <= (state_reg == S_FIRST) || (state_reg == S_SQW && sq_done);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        three_reg <= three_next;
        if (accept)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
            pz_reg <= z_coord;
        end
        if (state_reg == S_CMP)
        begin
            cand_reg <= dsum;
        end
        if (init_best)
        begin
            for (int i = 0; i < MAX_NEIGHBORS; i++)
            begin
                best_sq_reg[i] <= SQ_INF;
            end
        end
        else if (shift_en)
        begin
            best_sq_reg[pos_b]  <= best_sq_reg[posm1_b];
            best_idx_reg[pos_b] <= best_idx_reg[posm1_b];
        end
        else if (place_en)
        begin
            best_sq_reg[pos_b]  <= cand_reg;
            best_idx_reg[pos_b] <= j_reg;
        end
        rank_reg <= RANK_W'(pos_reg);
    end

    pknn_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .go(sq_go), .value(best_sq_reg[pos_b]),
        .done(sq_done), .root(sq_root));

    logic first_q;
    logic [PIDX_W-1:0] nidx_q;
    logic [DIST_W-1:0] dist_q;
    logic              last_q;

    always_ff @(posedge clk)
    begin
        first_q <= (state_reg == S_FIRST);
        nidx_q  <= PIDX_W'(best_idx_reg[pos_b]);
        dist_q  <= sq_root[DIST_W-1:0];
        last_q  <= (state_reg == S_FIRST) || (pos_reg == k_reg - 1'b1);
    end

    assign result_valid   = rv_reg;
    assign point_index    = first_q ? '0 : PIDX_W'(cur_reg);
    assign neighbor_rank  = first_q ? '0 : rank_reg;
    assign neighbor_index = first_q ? '0 : nidx_q;
    assign distance       = first_q ? '0 : dist_q;
    assign neighbor_valid = !first_q;
    assign last           = last_q;

endmodule
